### src/i2cmbs_pkg.sv
package i2cmbs_pkg;

    typedef enum logic [1:0] {
        REQ_QUEUE       = 2'd0,
        REQ_START_WRITE = 2'd1,
        REQ_START_READ  = 2'd2,
        REQ_BUS_EVENT   = 2'd3
    } t_req_type;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_READ  = 2'd2
    } t_xfer_mode;

    typedef enum logic [2:0] {
        ST_NONE      = 3'd0,
        ST_SUCCESS   = 3'd1,
        ST_NACK_ADDR = 3'd2,
        ST_NACK_DATA = 3'd3,
        ST_REJECTED  = 3'd4
    } t_status;

endpackage

### src/i2c_master_byte_sequencer.sv
// Path: a word accepted on the input passes the input register, then decision
// logic into the result register. Throughput: one word per cycle unless the
// output stalls, set by the single decision stage; the queue read is
// prefetched so a bus event never waits on the memory port.
// Reset: synchronous, active low; clears the transfer state, the queue
// pointers and both valid flags. Queue contents are undefined until written.
module i2c_master_byte_sequencer #(
    parameter int TX_DEPTH = 16,
    parameter int MAX_READ = 255
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_req_type,
    input  logic [7:0] i_data_byte,
    input  logic [6:0] i_target_address,
    input  logic [7:0] i_read_length,
    input  logic       i_stop_requested,
    input  logic       i_ack_received,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_bus_byte,
    output logic       o_bus_byte_valid,
    output logic       o_gen_start,
    output logic       o_ack_to_send,
    output logic       o_gen_stop,
    output logic       o_release_bus,
    output logic [7:0] o_rx_byte,
    output logic       o_rx_valid,
    output logic       o_done_res,
    output logic [2:0] o_status,
    output logic [7:0] o_rx_count
);

    localparam int PTR_W = $clog2(TX_DEPTH);
    localparam int FILL_W = $clog2(TX_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(TX_DEPTH - 1);
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(TX_DEPTH);
    localparam logic [7:0] READ_CAP = (MAX_READ > 255) ? 8'd255 : 8'(MAX_READ);

    // Input register.
    logic       r_in_valid;
    logic [1:0] r_in_req_type;
    logic [7:0] r_in_data_byte;
    logic [6:0] r_in_target_address;
    logic [7:0] r_in_read_length;
    logic       r_in_stop_requested;
    logic       r_in_ack_received;

    // Transfer state.
    i2cmbs_pkg::t_xfer_mode r_mode, n_mode;
    logic              r_in_tx, n_in_tx;
    logic              r_start_phase, n_start_phase;
    logic              r_stop_at_end, n_stop_at_end;
    logic              r_last_ack, n_last_ack;
    logic [7:0]        r_remaining, n_remaining;
    logic [7:0]        r_requested, n_requested;
    logic [PTR_W-1:0]  r_head, n_head;
    logic [PTR_W-1:0]  r_tail, n_tail;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic [FILL_W-1:0] r_fill_at_start, n_fill_at_start;

    logic [7:0] r_queue [TX_DEPTH];
    logic [7:0] r_head_data;

    // Result register.
    logic       r_out_valid;
    logic [7:0] r_bus_byte, n_bus_byte;
    logic       r_bus_byte_valid, n_bus_byte_valid;
    logic       r_gen_start, n_gen_start;
    logic       r_ack_to_send, n_ack_to_send;
    logic       r_gen_stop, n_gen_stop;
    logic       r_release_bus, n_release_bus;
    logic [7:0] r_rx_byte, n_rx_byte;
    logic       r_rx_valid, n_rx_valid;
    logic       r_done_res, n_done_res;
    i2cmbs_pkg::t_status r_status, n_status;
    logic [7:0] r_rx_count, n_rx_count;

    logic       w_fire;
    logic       w_start_ok;
    logic       w_reject;
    logic       w_queue_ok;
    logic       w_event;
    logic       w_nack;
    logic       w_eff_ack;
    logic       w_pop;
    logic       w_write_empty;
    logic       w_read_event;
    logic       w_read_data;
    logic       w_store;
    logic [7:0] w_rem_dec;
    logic       w_finish;
    logic [7:0] w_len;
    i2cmbs_pkg::t_req_type w_req;

    assign w_fire     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_fire;

    always_comb begin
        w_req = i2cmbs_pkg::t_req_type'(r_in_req_type);
        w_len = (r_in_read_length > READ_CAP) ? READ_CAP : r_in_read_length;

        w_start_ok = (w_req == i2cmbs_pkg::REQ_START_WRITE
                      || w_req == i2cmbs_pkg::REQ_START_READ)
                     && r_mode == i2cmbs_pkg::MODE_IDLE
                     && !(w_req == i2cmbs_pkg::REQ_START_WRITE && r_in_target_address == 7'd0);
        w_reject = (w_req == i2cmbs_pkg::REQ_START_WRITE
                    || w_req == i2cmbs_pkg::REQ_START_READ) && !w_start_ok;
        w_queue_ok = w_req == i2cmbs_pkg::REQ_QUEUE
                     && r_mode != i2cmbs_pkg::MODE_WRITE && r_fill != FILL_MAX;

        w_event   = w_req == i2cmbs_pkg::REQ_BUS_EVENT && r_mode != i2cmbs_pkg::MODE_IDLE;
        w_nack    = w_event && r_in_tx && !r_in_ack_received;
        w_eff_ack = (w_event && r_in_tx) ? r_in_ack_received : r_last_ack;

        w_write_empty = w_event && !w_nack && r_mode == i2cmbs_pkg::MODE_WRITE
                        && r_fill == '0;
        w_pop         = w_event && !w_nack && r_mode == i2cmbs_pkg::MODE_WRITE
                        && r_fill != '0;
        w_read_event  = w_event && !w_nack && r_mode == i2cmbs_pkg::MODE_READ;
        w_read_data   = w_read_event && !r_start_phase;
        w_store       = w_read_data && r_remaining != 8'd0;
        w_rem_dec     = w_store ? (r_remaining - 8'd1) : r_remaining;
        w_finish      = w_nack || w_write_empty || (w_read_data && w_rem_dec == 8'd0);
    end

    always_comb begin
        n_mode = r_mode;
        if (w_fire) begin
            priority if (w_start_ok) begin
                n_mode = (w_req == i2cmbs_pkg::REQ_START_READ) ? i2cmbs_pkg::MODE_READ
                                                                : i2cmbs_pkg::MODE_WRITE;
            end else if (w_finish) begin
                n_mode = i2cmbs_pkg::MODE_IDLE;
            end else begin
                n_mode = r_mode;
            end
        end
    end

    always_comb begin
        n_in_tx         = r_in_tx;
        n_start_phase   = r_start_phase;
        n_stop_at_end   = r_stop_at_end;
        n_last_ack      = r_last_ack;
        n_remaining     = r_remaining;
        n_requested     = r_requested;
        n_head          = r_head;
        n_tail          = r_tail;
        n_fill          = r_fill;
        n_fill_at_start = r_fill_at_start;

        n_bus_byte       = 8'd0;
        n_bus_byte_valid = 1'b0;
        n_gen_start      = 1'b0;
        n_ack_to_send    = 1'b0;
        n_gen_stop       = 1'b0;
        n_release_bus    = 1'b0;
        n_rx_byte        = 8'd0;
        n_rx_valid       = 1'b0;
        n_done_res       = 1'b0;
        n_status         = i2cmbs_pkg::ST_NONE;

        if (w_queue_ok) begin
            n_tail = (r_tail == PTR_LAST) ? '0 : r_tail + 1'b1;
            n_fill = r_fill + 1'b1;
        end

        if (w_reject) begin
            n_status = i2cmbs_pkg::ST_REJECTED;
        end

        if (w_start_ok) begin
            n_bus_byte       = {r_in_target_address, w_req == i2cmbs_pkg::REQ_START_READ};
            n_bus_byte_valid = 1'b1;
            n_gen_start      = 1'b1;
            n_in_tx          = 1'b1;
            n_start_phase    = 1'b1;
            n_stop_at_end    = r_in_stop_requested;
            n_last_ack       = 1'b0;
            n_fill_at_start  = r_fill;
            if (w_req == i2cmbs_pkg::REQ_START_READ) begin
                n_remaining = w_len;
                n_requested = w_len;
            end else begin
                n_remaining = 8'd0;
                n_requested = 8'd0;
            end
        end

        if (w_event) begin
            n_start_phase = 1'b0;
            n_last_ack    = w_eff_ack;
        end

        if (w_pop) begin
            n_bus_byte       = r_head_data;
            n_bus_byte_valid = 1'b1;
            n_head           = (r_head == PTR_LAST) ? '0 : r_head + 1'b1;
            n_fill           = r_fill - 1'b1;
        end

        if (w_read_event) begin
            n_in_tx = 1'b0;
            if (r_start_phase) begin
                n_ack_to_send = r_remaining != 8'd0;
            end else begin
                n_ack_to_send = r_remaining > 8'd1;
            end
        end

        if (w_store) begin
            n_rx_byte   = r_in_data_byte;
            n_rx_valid  = 1'b1;
            n_remaining = w_rem_dec;
        end

        if (w_finish) begin
            n_gen_stop    = r_stop_at_end;
            n_release_bus = !r_stop_at_end;
            n_done_res    = 1'b1;
            n_in_tx       = 1'b0;
            n_start_phase = 1'b0;
            if (w_eff_ack) begin
                n_status = i2cmbs_pkg::ST_SUCCESS;
            end else if (r_mode == i2cmbs_pkg::MODE_WRITE && r_fill != r_fill_at_start) begin
                n_status = i2cmbs_pkg::ST_NACK_DATA;
            end else begin
                n_status = i2cmbs_pkg::ST_NACK_ADDR;
            end
        end

        if (!w_fire) begin
            n_in_tx         = r_in_tx;
            n_start_phase   = r_start_phase;
            n_stop_at_end   = r_stop_at_end;
            n_last_ack      = r_last_ack;
            n_remaining     = r_remaining;
            n_requested     = r_requested;
            n_head          = r_head;
            n_tail          = r_tail;
            n_fill          = r_fill;
            n_fill_at_start = r_fill_at_start;
        end

        n_rx_count = n_requested - n_remaining;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_req_type       <= i_req_type;
            r_in_data_byte      <= i_data_byte;
            r_in_target_address <= i_target_address;
            r_in_read_length    <= i_read_length;
            r_in_stop_requested <= i_stop_requested;
            r_in_ack_received   <= i_ack_received;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode          <= i2cmbs_pkg::MODE_IDLE;
            r_in_tx         <= 1'b0;
            r_start_phase   <= 1'b0;
            r_stop_at_end   <= 1'b0;
            r_last_ack      <= 1'b0;
            r_remaining     <= 8'd0;
            r_requested     <= 8'd0;
            r_head          <= '0;
            r_tail          <= '0;
            r_fill          <= '0;
            r_fill_at_start <= '0;
        end else begin
            r_mode          <= n_mode;
            r_in_tx         <= n_in_tx;
            r_start_phase   <= n_start_phase;
            r_stop_at_end   <= n_stop_at_end;
            r_last_ack      <= n_last_ack;
            r_remaining     <= n_remaining;
            r_requested     <= n_requested;
            r_head          <= n_head;
            r_tail          <= n_tail;
            r_fill          <= n_fill;
            r_fill_at_start <= n_fill_at_start;
        end
    end

    // The byte at the next head position is read ahead, with a bypass for a
    // byte written to that position in the same cycle.
    always_ff @(posedge i_clk) begin
        if (w_fire && w_queue_ok) begin
            r_queue[r_tail] <= r_in_data_byte;
        end
        if (w_fire && w_queue_ok && r_tail == n_head) begin
            r_head_data <= r_in_data_byte;
        end else begin
            r_head_data <= r_queue[n_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_bus_byte       <= n_bus_byte;
            r_bus_byte_valid <= n_bus_byte_valid;
            r_gen_start      <= n_gen_start;
            r_ack_to_send    <= n_ack_to_send;
            r_gen_stop       <= n_gen_stop;
            r_release_bus    <= n_release_bus;
            r_rx_byte        <= n_rx_byte;
            r_rx_valid       <= n_rx_valid;
            r_done_res       <= n_done_res;
            r_status         <= n_status;
            r_rx_count       <= n_rx_count;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_bus_byte       = r_bus_byte;
    assign o_bus_byte_valid = r_bus_byte_valid;
    assign o_gen_start      = r_gen_start;
    assign o_ack_to_send    = r_ack_to_send;
    assign o_gen_stop       = r_gen_stop;
    assign o_release_bus    = r_release_bus;
    assign o_rx_byte        = r_rx_byte;
    assign o_rx_valid       = r_rx_valid;
    assign o_done_res       = r_done_res;
    assign o_status         = r_status;
    assign o_rx_count       = r_rx_count;

endmodule
